FILE: design/ptc_pkg.sv
// ----------------------------------------------------------------------------
// ptc_pkg
// Shared types, codes and micro-program for the sensor compensation block.
// ----------------------------------------------------------------------------
package ptc_pkg;

    localparam int DataW = 64;
    localparam int PcW   = 6;

    // Configuration register indexes
    localparam logic [2:0] CFG_HAS_HUMIDITY   = 3'd0;
    localparam logic [2:0] CFG_CAL_TEMPERATURE = 3'd1;
    localparam logic [2:0] CFG_CAL_PRESSURE_A = 3'd2;
    localparam logic [2:0] CFG_CAL_PRESSURE_B = 3'd3;
    localparam logic [2:0] CFG_CAL_PRESSURE_C = 3'd4;
    localparam logic [2:0] CFG_CAL_HUMIDITY   = 3'd5;

    // Result status codes
    localparam logic STATUS_OK          = 1'b0;
    localparam logic STATUS_UNSUPPORTED = 1'b1;

    // Action codes
    localparam logic ACTION_TP  = 1'b0;
    localparam logic ACTION_HUM = 1'b1;

    typedef struct packed {
        logic        action;
        logic [19:0] raw_temperature;
        logic [19:0] raw_pressure;
        logic [15:0] raw_humidity;
    } ptc_in_t;

    typedef struct packed {
        logic               status;
        logic signed [15:0] temperature_centi;
        logic [24:0]        pressure_q8;
        logic [16:0]        humidity_q10;
    } ptc_out_t;

    typedef struct packed {
        logic               has_humidity;
        logic [47:0]        cal_temperature;
        logic [63:0]        cal_pressure_a;
        logic [63:0]        cal_pressure_b;
        logic signed [15:0] cal_pressure_c;
        logic [63:0]        cal_humidity;
    } ptc_cfg_t;

    typedef enum logic [3:0] {
        OP_ADD,
        OP_SUB,
        OP_ASR,
        OP_MUL0,
        OP_MUL24,
        OP_DIV,
        OP_TEMP,
        OP_PRES,
        OP_HUM,
        OP_END
    } op_t;

    typedef enum logic [5:0] {
        SRC_R0, SRC_R1, SRC_R2, SRC_R3, SRC_R4, SRC_R5, SRC_R6, SRC_R7,
        SRC_ZERO, SRC_ONE, SRC_D1, SRC_D2, SRC_T2, SRC_T3, SRC_V1,
        SRC_P6S, SRC_P5X, SRC_P4X, SRC_P3S, SRC_P2X, SRC_P1X, SRC_PRAW,
        SRC_K6250, SRC_P9X, SRC_P8X, SRC_P7X, SRC_HALF15, SRC_VH,
        SRC_HRAW, SRC_H4X, SRC_H5K, SRC_H3X, SRC_H6X, SRC_H2K, SRC_H1X
    } src_t;

    typedef struct packed {
        op_t        op;
        logic [2:0] dst;
        src_t       src_a;
        src_t       src_b;
        logic [4:0] sh;
    } instr_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SRC_A,
        ST_SRC_B,
        ST_EXEC,
        ST_WAIT,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic       start;
        logic       load_a;
        logic       load_b;
        logic       exec;
        logic       wb;
        logic       load_out;
        src_t       sel;
        op_t        op;
        logic [2:0] dst;
        logic [4:0] sh;
    } ptc_cmd_t;

    typedef struct packed {
        logic unit_done;
    } ptc_sts_t;

    localparam logic [PcW-1:0] PC_TP  = 6'd0;
    localparam logic [PcW-1:0] PC_HUM = 6'd36;

    function automatic instr_t ucode(input logic [PcW-1:0] pc);
        instr_t u;
        u = '{OP_END, 3'd0, SRC_ZERO, SRC_ZERO, 5'd0};
        case (pc)
            // temperature
            6'd0:  u = '{OP_MUL0,  3'd0, SRC_D1,   SRC_T2,     5'd0};
            6'd1:  u = '{OP_MUL24, 3'd1, SRC_D2,   SRC_D2,     5'd0};
            6'd2:  u = '{OP_MUL0,  3'd1, SRC_R1,   SRC_T3,     5'd0};
            6'd3:  u = '{OP_ADD,   3'd0, SRC_R0,   SRC_R1,     5'd0};
            6'd4:  u = '{OP_TEMP,  3'd0, SRC_R0,   SRC_ZERO,   5'd0};
            // pressure
            6'd5:  u = '{OP_ADD,   3'd1, SRC_V1,   SRC_ZERO,   5'd0};
            6'd6:  u = '{OP_MUL24, 3'd2, SRC_R1,   SRC_R1,     5'd0};
            6'd7:  u = '{OP_MUL24, 3'd3, SRC_R2,   SRC_P6S,    5'd0};
            6'd8:  u = '{OP_MUL24, 3'd4, SRC_R1,   SRC_P5X,    5'd0};
            6'd9:  u = '{OP_ADD,   3'd3, SRC_R3,   SRC_R4,     5'd0};
            6'd10: u = '{OP_ASR,   3'd3, SRC_R3,   SRC_ZERO,   5'd2};
            6'd11: u = '{OP_ADD,   3'd3, SRC_R3,   SRC_P4X,    5'd0};
            6'd12: u = '{OP_MUL24, 3'd4, SRC_R2,   SRC_P3S,    5'd0};
            6'd13: u = '{OP_MUL24, 3'd5, SRC_R1,   SRC_P2X,    5'd0};
            6'd14: u = '{OP_ADD,   3'd4, SRC_R4,   SRC_R5,     5'd0};
            6'd15: u = '{OP_ASR,   3'd4, SRC_R4,   SRC_ZERO,   5'd19};
            6'd16: u = '{OP_ASR,   3'd4, SRC_R4,   SRC_ZERO,   5'd15};
            6'd17: u = '{OP_ADD,   3'd4, SRC_ONE,  SRC_R4,     5'd0};
            6'd18: u = '{OP_MUL24, 3'd4, SRC_R4,   SRC_P1X,    5'd0};
            6'd19: u = '{OP_ASR,   3'd3, SRC_R3,   SRC_ZERO,   5'd12};
            6'd20: u = '{OP_SUB,   3'd5, SRC_PRAW, SRC_R3,     5'd0};
            6'd21: u = '{OP_MUL24, 3'd5, SRC_R5,   SRC_K6250,  5'd0};
            6'd22: u = '{OP_DIV,   3'd5, SRC_R5,   SRC_R4,     5'd0};
            6'd23: u = '{OP_MUL24, 3'd6, SRC_R5,   SRC_R5,     5'd0};
            6'd24: u = '{OP_ASR,   3'd6, SRC_R6,   SRC_ZERO,   5'd31};
            6'd25: u = '{OP_MUL24, 3'd6, SRC_R6,   SRC_P9X,    5'd0};
            6'd26: u = '{OP_MUL24, 3'd7, SRC_R5,   SRC_P8X,    5'd0};
            6'd27: u = '{OP_ASR,   3'd7, SRC_R7,   SRC_ZERO,   5'd15};
            6'd28: u = '{OP_ADD,   3'd6, SRC_R6,   SRC_R7,     5'd0};
            6'd29: u = '{OP_ADD,   3'd6, SRC_R6,   SRC_P7X,    5'd0};
            6'd30: u = '{OP_ASR,   3'd6, SRC_R6,   SRC_ZERO,   5'd4};
            6'd31: u = '{OP_ADD,   3'd5, SRC_R5,   SRC_R6,     5'd0};
            6'd32: u = '{OP_ADD,   3'd5, SRC_R5,   SRC_HALF15, 5'd0};
            6'd33: u = '{OP_ASR,   3'd5, SRC_R5,   SRC_ZERO,   5'd16};
            6'd34: u = '{OP_PRES,  3'd0, SRC_R5,   SRC_ZERO,   5'd0};
            6'd35: u = '{OP_END,   3'd0, SRC_ZERO, SRC_ZERO,   5'd0};
            // humidity
            6'd36: u = '{OP_MUL24, 3'd1, SRC_H5K,  SRC_VH,     5'd0};
            6'd37: u = '{OP_ADD,   3'd1, SRC_H4X,  SRC_R1,     5'd0};
            6'd38: u = '{OP_SUB,   3'd1, SRC_HRAW, SRC_R1,     5'd0};
            6'd39: u = '{OP_MUL24, 3'd2, SRC_VH,   SRC_H3X,    5'd0};
            6'd40: u = '{OP_ASR,   3'd2, SRC_R2,   SRC_ZERO,   5'd26};
            6'd41: u = '{OP_ADD,   3'd2, SRC_ONE,  SRC_R2,     5'd0};
            6'd42: u = '{OP_MUL24, 3'd3, SRC_VH,   SRC_H6X,    5'd0};
            6'd43: u = '{OP_ASR,   3'd3, SRC_R3,   SRC_ZERO,   5'd26};
            6'd44: u = '{OP_MUL24, 3'd3, SRC_R3,   SRC_R2,     5'd0};
            6'd45: u = '{OP_ADD,   3'd3, SRC_ONE,  SRC_R3,     5'd0};
            6'd46: u = '{OP_MUL24, 3'd4, SRC_H2K,  SRC_R3,     5'd0};
            6'd47: u = '{OP_MUL24, 3'd4, SRC_R1,   SRC_R4,     5'd0};
            6'd48: u = '{OP_MUL24, 3'd5, SRC_R4,   SRC_H1X,    5'd0};
            6'd49: u = '{OP_ASR,   3'd5, SRC_R5,   SRC_ZERO,   5'd19};
            6'd50: u = '{OP_SUB,   3'd5, SRC_ONE,  SRC_R5,     5'd0};
            6'd51: u = '{OP_MUL24, 3'd4, SRC_R4,   SRC_R5,     5'd0};
            6'd52: u = '{OP_HUM,   3'd0, SRC_R4,   SRC_ZERO,   5'd0};
            default: u = '{OP_END, 3'd0, SRC_ZERO, SRC_ZERO,   5'd0};
        endcase
        return u;
    endfunction

endpackage

FILE: design/ptc_mul.sv
// ----------------------------------------------------------------------------
// ptc_mul
// Signed 64x64 multiply over four 32x32 partial products, then an optional
// 24-bit shift with floor, and saturate to 64 bits.
// ----------------------------------------------------------------------------
module ptc_mul (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               start,
    input  logic               sh24,
    input  logic signed [63:0] a,
    input  logic signed [63:0] b,
    output logic               done,
    output logic signed [63:0] res
);
    import ptc_pkg::*;

    localparam logic [2:0] LastPart = 3'd4;

    logic [63:0]        ma_reg, mb_reg;
    logic               neg_reg, sh_reg;
    logic [127:0]       acc_reg;
    logic [2:0]         cnt_reg;
    logic               busy_reg, done_reg;
    logic signed [63:0] res_reg;

    logic [31:0]  pa, pb;
    logic [63:0]  pp;
    logic [6:0]   pp_sh;
    logic [127:0] shifted, m;
    logic signed [63:0] res_next;

    always_comb begin
        pa      = cnt_reg[0] ? ma_reg[63:32] : ma_reg[31:0];
        pb      = cnt_reg[1] ? mb_reg[63:32] : mb_reg[31:0];
        pp      = 64'(pa) * 64'(pb);
        pp_sh   = 7'((2'(cnt_reg[0]) + 2'(cnt_reg[1]))) << 5;
        shifted = sh_reg ? (acc_reg >> 24) : acc_reg;
        m       = shifted + 128'(neg_reg & sh_reg & (|acc_reg[23:0]));
        if (neg_reg) begin
            res_next = (|m[127:63]) ? {1'b1, 63'd0} : -$signed(m[63:0]);
        end else begin
            res_next = (|m[127:63]) ? {1'b0, {63{1'b1}}} : $signed(m[63:0]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                if (cnt_reg == LastPart) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end else begin
                    cnt_reg <= cnt_reg + 3'd1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            ma_reg  <= a[63] ? 64'(-a) : 64'(a);
            mb_reg  <= b[63] ? 64'(-b) : 64'(b);
            neg_reg <= a[63] ^ b[63];
            sh_reg  <= sh24;
            acc_reg <= '0;
        end else if (busy_reg && cnt_reg != LastPart) begin
            acc_reg <= acc_reg + (128'(pp) << pp_sh);
        end else if (busy_reg) begin
            res_reg <= res_next;
        end
    end

    assign done = done_reg;
    assign res  = res_reg;

endmodule

FILE: design/ptc_div.sv
// ----------------------------------------------------------------------------
// ptc_div
// Signed Q24 divide, truncated toward zero and saturated; restoring,
// one quotient bit per cycle.
// ----------------------------------------------------------------------------
module ptc_div (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               start,
    input  logic signed [63:0] n,
    input  logic signed [63:0] d,
    output logic               done,
    output logic signed [63:0] res
);
    import ptc_pkg::*;

    localparam int DvdW = DataW + 24;
    localparam logic [6:0] LastStep = 7'(DvdW - 1);

    logic [DvdW-1:0]    dvd_reg;
    logic [63:0]        rem_reg, ud_reg;
    logic               neg_reg;
    logic [6:0]         cnt_reg;
    logic               busy_reg, fin_reg, done_reg;
    logic signed [63:0] res_reg;

    logic [64:0] r_sh, r_sub;
    logic        qbit;

    always_comb begin
        r_sh  = {rem_reg, dvd_reg[DvdW-1]};
        r_sub = r_sh - {1'b0, ud_reg};
        qbit  = (r_sh >= {1'b0, ud_reg});
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            fin_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            fin_reg  <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 7'd1;
                if (cnt_reg == LastStep) begin
                    busy_reg <= 1'b0;
                    fin_reg  <= 1'b1;
                end
            end else if (fin_reg) begin
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            dvd_reg <= {(n[63] ? 64'(-n) : 64'(n)), 24'd0};
            ud_reg  <= d[63] ? 64'(-d) : 64'(d);
            rem_reg <= '0;
            neg_reg <= n[63] ^ d[63];
        end else if (busy_reg) begin
            rem_reg <= qbit ? r_sub[63:0] : r_sh[63:0];
            dvd_reg <= {dvd_reg[DvdW-2:0], qbit};
        end else if (fin_reg) begin
            if (|dvd_reg[DvdW-1:63]) begin
                res_reg <= neg_reg ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
            end else begin
                res_reg <= neg_reg ? -$signed(dvd_reg[63:0]) : $signed(dvd_reg[63:0]);
            end
        end
    end

    assign done = done_reg;
    assign res  = res_reg;

endmodule

FILE: design/ptc_dpath.sv
// ----------------------------------------------------------------------------
// ptc_dpath
// Datapath: operand sources, register file, saturating ALU, multiply and
// divide units, result registers.
// ----------------------------------------------------------------------------
module ptc_dpath (
    input  logic              aclk,
    input  logic              aresetn,
    input  ptc_pkg::ptc_cmd_t cmd,
    input  ptc_pkg::ptc_in_t  s_data,
    input  ptc_pkg::ptc_cfg_t cfg,
    output ptc_pkg::ptc_sts_t sts,
    output ptc_pkg::ptc_out_t m_data
);
    import ptc_pkg::*;

    localparam logic signed [63:0] Q24One = 64'sd1 <<< 24;
    localparam logic signed [63:0] SMax   = {1'b0, {63{1'b1}}};
    localparam logic signed [63:0] SMin   = {1'b1, 63'd0};

    logic [19:0] raw_t_reg, raw_p_reg;
    logic [15:0] raw_h_reg;
    logic signed [63:0] rf_reg [8];
    logic signed [63:0] opa_reg, opb_reg;
    logic signed [31:0] fine_reg;
    logic               dz_reg;
    logic               status_reg;
    logic signed [15:0] centi_reg;
    logic [24:0]        pres_reg;
    logic [16:0]        hum_reg;
    ptc_out_t           out_reg;

    logic signed [63:0] src_val, fine_ext;
    logic               mul_done, div_done, mul_start, div_start;
    logic signed [63:0] mul_res, div_res;

    function automatic logic signed [63:0] sat_addsub(
        input logic signed [63:0] a,
        input logic signed [63:0] b,
        input logic               sub
    );
        logic [64:0] s;
        s = sub ? ({a[63], a} - {b[63], b}) : ({a[63], a} + {b[63], b});
        if (s[64] != s[63]) begin
            return s[64] ? SMin : SMax;
        end
        return $signed(s[63:0]);
    endfunction

    assign fine_ext = 64'(fine_reg);

    always_comb begin
        src_val = '0;
        if (cmd.sel inside {[SRC_R0:SRC_R7]}) begin
            src_val = rf_reg[3'(cmd.sel)];
        end else begin
            case (cmd.sel)
                SRC_ZERO:   src_val = '0;
                SRC_ONE:    src_val = Q24One;
                SRC_D1:     src_val = (64'(raw_t_reg) << 10)
                                    - (64'(cfg.cal_temperature[15:0]) << 14);
                SRC_D2:     src_val = (64'(raw_t_reg) << 7)
                                    - (64'(cfg.cal_temperature[15:0]) << 11);
                SRC_T2:     src_val = 64'($signed(cfg.cal_temperature[31:16]));
                SRC_T3:     src_val = 64'($signed(cfg.cal_temperature[47:32]));
                SRC_V1:     src_val = (fine_ext <<< 23) - (64'sd64000 <<< 24);
                SRC_P6S:    src_val = 64'($signed(cfg.cal_pressure_b[31:16])) <<< 9;
                SRC_P5X:    src_val = 64'($signed(cfg.cal_pressure_b[15:0])) <<< 25;
                SRC_P4X:    src_val = 64'($signed(cfg.cal_pressure_a[63:48])) <<< 40;
                SRC_P3S:    src_val = 64'($signed(cfg.cal_pressure_a[47:32])) <<< 5;
                SRC_P2X:    src_val = 64'($signed(cfg.cal_pressure_a[31:16])) <<< 24;
                SRC_P1X:    src_val = 64'(cfg.cal_pressure_a[15:0]) << 24;
                SRC_PRAW:   src_val = (64'(21'h100000) - 64'(raw_p_reg)) << 24;
                SRC_K6250:  src_val = 64'sd6250 <<< 24;
                SRC_P9X:    src_val = 64'(cfg.cal_pressure_c) <<< 24;
                SRC_P8X:    src_val = 64'($signed(cfg.cal_pressure_b[63:48])) <<< 24;
                SRC_P7X:    src_val = 64'($signed(cfg.cal_pressure_b[47:32])) <<< 24;
                SRC_HALF15: src_val = 64'sd1 <<< 15;
                SRC_VH:     src_val = (fine_ext - 64'sd76800) <<< 24;
                SRC_HRAW:   src_val = 64'(raw_h_reg) << 24;
                SRC_H4X:    src_val = 64'(cfg.cal_humidity[43:32]) << 30;
                SRC_H5K:    src_val = 64'(cfg.cal_humidity[55:44]) << 10;
                SRC_H3X:    src_val = 64'(cfg.cal_humidity[31:24]) << 24;
                SRC_H6X:    src_val = 64'($signed(cfg.cal_humidity[63:56])) <<< 24;
                SRC_H2K:    src_val = 64'($signed(cfg.cal_humidity[23:8])) <<< 8;
                SRC_H1X:    src_val = 64'(cfg.cal_humidity[7:0]) << 24;
                default:    src_val = '0;
            endcase
        end
    end

    assign mul_start = cmd.exec && (cmd.op == OP_MUL0 || cmd.op == OP_MUL24);
    assign div_start = cmd.exec && (cmd.op == OP_DIV);

    ptc_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start),
        .sh24    (cmd.op == OP_MUL24),
        .a       (opa_reg),
        .b       (opb_reg),
        .done    (mul_done),
        .res     (mul_res)
    );

    ptc_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .n       (opa_reg),
        .d       (opb_reg),
        .done    (div_done),
        .res     (div_res)
    );

    assign sts.unit_done = mul_done | div_done;

    // Temperature, pressure and humidity finishing steps
    logic [63:0]        t_mag;
    logic [31:0]        t_int;
    logic signed [31:0] tf_next;
    logic signed [63:0] c_sum, c_q;
    logic signed [15:0] centi_next;
    logic [24:0]        pres_next;
    logic signed [63:0] h_v;
    logic [63:0]        h_r;

    always_comb begin
        t_mag   = opa_reg[63] ? 64'(-opa_reg) : 64'(opa_reg);
        t_int   = 32'(t_mag >> 24);
        tf_next = opa_reg[63] ? -$signed(t_int) : $signed(t_int);
        c_sum   = (opa_reg <<< 2) + opa_reg + (64'sd1 <<< 31);
        c_q     = c_sum >>> 32;
        if (c_q > 64'sd32767) begin
            centi_next = 16'sh7fff;
        end else if (c_q < -64'sd32768) begin
            centi_next = 16'sh8000;
        end else begin
            centi_next = c_q[15:0];
        end
        if (dz_reg || opa_reg[63]) begin
            pres_next = '0;
        end else if (opa_reg > 64'sd33554431) begin
            pres_next = '1;
        end else begin
            pres_next = opa_reg[24:0];
        end
        if (opa_reg[63]) begin
            h_v = '0;
        end else if (opa_reg > (64'sd100 <<< 24)) begin
            h_v = 64'sd100 <<< 24;
        end else begin
            h_v = opa_reg;
        end
        h_r = 64'(h_v + (64'sd1 <<< 13)) >> 14;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fine_reg <= '0;
        end else if (cmd.exec && cmd.op == OP_TEMP) begin
            fine_reg <= tf_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            raw_t_reg  <= s_data.raw_temperature;
            raw_p_reg  <= s_data.raw_pressure;
            raw_h_reg  <= s_data.raw_humidity;
            status_reg <= (s_data.action == ACTION_HUM && !cfg.has_humidity)
                          ? STATUS_UNSUPPORTED : STATUS_OK;
            centi_reg  <= '0;
            pres_reg   <= '0;
            hum_reg    <= '0;
            dz_reg     <= 1'b0;
        end
        if (cmd.load_a) begin
            opa_reg <= src_val;
        end
        if (cmd.load_b) begin
            opb_reg <= src_val;
        end
        if (cmd.exec) begin
            case (cmd.op)
                OP_ADD:  rf_reg[cmd.dst] <= sat_addsub(opa_reg, opb_reg, 1'b0);
                OP_SUB:  rf_reg[cmd.dst] <= sat_addsub(opa_reg, opb_reg, 1'b1);
                OP_ASR:  rf_reg[cmd.dst] <= opa_reg >>> cmd.sh;
                OP_DIV:  dz_reg <= (opb_reg == '0);
                OP_TEMP: centi_reg <= centi_next;
                OP_PRES: pres_reg <= pres_next;
                OP_HUM:  hum_reg <= h_r[16:0];
                default: ;
            endcase
        end
        if (cmd.wb) begin
            rf_reg[cmd.dst] <= (cmd.op == OP_DIV) ? div_res : mul_res;
        end
        if (cmd.load_out) begin
            out_reg.status            <= status_reg;
            out_reg.temperature_centi <= centi_reg;
            out_reg.pressure_q8       <= pres_reg;
            out_reg.humidity_q10      <= hum_reg;
        end
    end

    assign m_data = out_reg;

endmodule

FILE: design/ptc_ctrl.sv
// ----------------------------------------------------------------------------
// ptc_ctrl
// Controller: micro-program sequencer and request handshakes.
// ----------------------------------------------------------------------------
module ptc_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    input  logic              s_action,
    input  logic              has_humidity,
    input  logic              m_ready,
    input  ptc_pkg::ptc_sts_t sts,
    output logic              s_ready,
    output logic              m_valid,
    output ptc_pkg::ptc_cmd_t cmd
);
    import ptc_pkg::*;

    state_t           state_reg, state_next;
    logic [PcW-1:0]   pc_reg, pc_next;
    logic             m_valid_reg, m_valid_next;
    instr_t           instr;
    logic             accept, out_free;

    assign instr    = ucode(pc_reg);
    assign accept   = (state_reg == ST_IDLE) && s_valid;
    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        state_next   = state_reg;
        pc_next      = pc_reg;
        m_valid_next = m_valid_reg && !m_ready;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    if (s_action == ACTION_HUM && !has_humidity) begin
                        state_next = ST_DONE;
                    end else begin
                        state_next = ST_SRC_A;
                        pc_next    = (s_action == ACTION_HUM) ? PC_HUM : PC_TP;
                    end
                end
            end
            ST_SRC_A: begin
                state_next = (instr.op == OP_END) ? ST_DONE : ST_SRC_B;
            end
            ST_SRC_B: state_next = ST_EXEC;
            ST_EXEC: begin
                if (instr.op == OP_MUL0 || instr.op == OP_MUL24 || instr.op == OP_DIV) begin
                    state_next = ST_WAIT;
                end else begin
                    state_next = ST_SRC_A;
                    pc_next    = pc_reg + PcW'(1);
                end
            end
            ST_WAIT: begin
                if (sts.unit_done) begin
                    state_next = ST_SRC_A;
                    pc_next    = pc_reg + PcW'(1);
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    state_next   = ST_IDLE;
                    m_valid_next = 1'b1;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        cmd          = '0;
        cmd.op       = instr.op;
        cmd.dst      = instr.dst;
        cmd.sh       = instr.sh;
        cmd.sel      = (state_reg == ST_SRC_B) ? instr.src_b : instr.src_a;
        cmd.start    = accept;
        cmd.load_a   = (state_reg == ST_SRC_A) && (instr.op != OP_END);
        cmd.load_b   = (state_reg == ST_SRC_B);
        cmd.exec     = (state_reg == ST_EXEC);
        cmd.wb       = (state_reg == ST_WAIT) && sts.unit_done;
        cmd.load_out = (state_reg == ST_DONE) && out_free;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            pc_reg      <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            pc_reg      <= pc_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;

endmodule

FILE: design/pressure_temp_humidity_compensation.sv
// ----------------------------------------------------------------------------
// pressure_temp_humidity_compensation
// Calibration compensation of raw temperature, pressure and humidity readings.
// ----------------------------------------------------------------------------
// One request is worked at a time. A temperature/pressure request (action 0)
// runs 35 micro-instructions and an end step: thirteen multiplies on the
// shared 32x32 multiplier, one divide in the bit-serial divider and the rest
// plain steps. A humidity request runs eight multiplies and nine plain steps,
// and a humidity request on a part without humidity goes straight to its
// result. A finished result sits in the output register while the next request
// is taken; a result still waiting there holds the following one back. Fine
// temperature from the last action 0 is kept for later humidity requests and
// reads as zero after reset. Write the calibration registers only while the
// block is idle.
// ----------------------------------------------------------------------------
module pressure_temp_humidity_compensation (
    input  logic              aclk,
    input  logic              aresetn,
    // input requests
    input  logic              s_valid,
    output logic              s_ready,
    input  ptc_pkg::ptc_in_t  s_data,
    // results
    output logic              m_valid,
    input  logic              m_ready,
    output ptc_pkg::ptc_out_t m_data,
    // configuration write port
    input  logic              cfg_wr_en,
    input  logic [2:0]        cfg_index,
    input  logic [63:0]       cfg_wdata
);
    import ptc_pkg::*;

    ptc_cfg_t cfg_reg;
    ptc_cmd_t cmd;
    ptc_sts_t sts;

    // Calibration registers: take a write whenever enabled, drop unknown
    // indexes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_HAS_HUMIDITY:    cfg_reg.has_humidity    <= cfg_wdata[0];
                CFG_CAL_TEMPERATURE: cfg_reg.cal_temperature <= cfg_wdata[47:0];
                CFG_CAL_PRESSURE_A:  cfg_reg.cal_pressure_a  <= cfg_wdata;
                CFG_CAL_PRESSURE_B:  cfg_reg.cal_pressure_b  <= cfg_wdata;
                CFG_CAL_PRESSURE_C:  cfg_reg.cal_pressure_c  <= $signed(cfg_wdata[15:0]);
                CFG_CAL_HUMIDITY:    cfg_reg.cal_humidity    <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Sequencer: steps the micro-program and owns both handshakes.
    ptc_ctrl u_ctrl (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_action     (s_data.action),
        .has_humidity (cfg_reg.has_humidity),
        .m_ready      (m_ready),
        .sts          (sts),
        .s_ready      (s_ready),
        .m_valid      (m_valid),
        .cmd          (cmd)
    );

    // Datapath: Q24 fixed-point arithmetic and the result register.
    ptc_dpath u_dpath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .s_data  (s_data),
        .cfg     (cfg_reg),
        .sts     (sts),
        .m_data  (m_data)
    );

endmodule
